>>> rtl/assert_macros.svh
// Assertion macros used by the RTL top level of the scancode decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define KSD_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle check");
// Next-cycle implication, disabled while reset is asserted.
`define KSD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle check");
`else
`define KSD_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define KSD_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

>>> rtl/ksd_pkg.sv
// Package with types, byte codes and key lookup functions of the scancode decoder.
package ksd_pkg;

    localparam logic [7:0] BYTE_ACK   = 8'hFA;
    localparam logic [7:0] BYTE_NAK   = 8'hFE;
    localparam logic [7:0] BYTE_BREAK = 8'hF0;
    localparam logic [7:0] BYTE_EXT   = 8'hE0;

    localparam logic [7:0] CODE_SHIFT_L = 8'h12;
    localparam logic [7:0] CODE_SHIFT_R = 8'h59;
    localparam logic [7:0] CODE_CTRL    = 8'h14;
    localparam logic [7:0] CODE_ALT     = 8'h11;
    localparam logic [7:0] CODE_SCROLL  = 8'h7E;
    localparam logic [7:0] CODE_NUM     = 8'h77;
    localparam logic [7:0] CODE_CAPS    = 8'h58;

    localparam logic [5:0] MOD_LSHIFT = 6'b000001;
    localparam logic [5:0] MOD_RSHIFT = 6'b000010;
    localparam logic [5:0] MOD_LCTRL  = 6'b000100;
    localparam logic [5:0] MOD_RCTRL  = 6'b001000;
    localparam logic [5:0] MOD_LALT   = 6'b010000;
    localparam logic [5:0] MOD_RALT   = 6'b100000;

    localparam logic [2:0] LOCK_SCROLL = 3'b001;
    localparam logic [2:0] LOCK_NUM    = 3'b010;
    localparam logic [2:0] LOCK_CAPS   = 3'b100;

    typedef enum logic [2:0] {
        PH_WAIT      = 3'd0,
        PH_EXT       = 3'd1,
        PH_BREAK     = 3'd2,
        PH_FAKE      = 3'd3,
        PH_EXT_BREAK = 3'd4
    } t_phase;

    typedef enum logic {
        KIND_KEY = 1'b0,
        KIND_LED = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] scancode;
        logic       extended;
        logic       pressed;
        logic [5:0] modifiers;
        logic [2:0] locks;
    } t_result;

    function automatic logic [5:0] modifier_bit(input logic [7:0] code, input logic ext);
        logic [5:0] bits;
        bits = '0;
        if (!ext) begin
            if (code == CODE_SHIFT_L) bits = MOD_LSHIFT;
            else if (code == CODE_SHIFT_R) bits = MOD_RSHIFT;
            else if (code == CODE_CTRL) bits = MOD_LCTRL;
            else if (code == CODE_ALT) bits = MOD_LALT;
        end else begin
            if (code == CODE_CTRL) bits = MOD_RCTRL;
            else if (code == CODE_ALT) bits = MOD_RALT;
        end
        return bits;
    endfunction

    function automatic logic [2:0] lock_bit(input logic [7:0] code, input logic ext);
        logic [2:0] bits;
        bits = '0;
        if (!ext) begin
            if (code == CODE_SCROLL) bits = LOCK_SCROLL;
            else if (code == CODE_NUM) bits = LOCK_NUM;
            else if (code == CODE_CAPS) bits = LOCK_CAPS;
        end
        return bits;
    endfunction

endpackage

>>> rtl/ksd_if.sv
// Handshake interfaces for the received byte channel and the decoded result channel.
interface ksd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ksd_result_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] key_scancode;
    logic       is_extended;
    logic       is_pressed;
    logic [5:0] modifier_mask;
    logic [2:0] lock_mask;

    modport source (output valid, output result_kind, output key_scancode,
                    output is_extended, output is_pressed, output modifier_mask,
                    output lock_mask, input ready);
    modport sink (input valid, input result_kind, input key_scancode,
                  input is_extended, input is_pressed, input modifier_mask,
                  input lock_mask, output ready);
endinterface

>>> rtl/ksd_in_stage.sv
// Input register that holds one received byte until the decoder takes it.
module ksd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte,
    ksd_byte_if.sink   i_rx
);
    import ksd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    // The slot is free when empty or when its byte moves on this cycle.
    assign i_rx.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

>>> rtl/ksd_decode.sv
// Prefix state machine, lock flags and held modifiers of the scancode decoder.
module ksd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_ack_filter,
    output logic             o_emit,
    output ksd_pkg::t_result o_result
);
    import ksd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [2:0] r_locks;
    logic [2:0] n_locks;
    logic [5:0] r_mods;
    logic [5:0] n_mods;

    logic       filtered;
    logic       key_seen;
    logic       key_ext;
    logic       key_pressed;
    logic [2:0] lk;
    logic [5:0] md;

    assign filtered = i_ack_filter && ((i_byte == BYTE_ACK) || (i_byte == BYTE_NAK));

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (!filtered) begin
            case (r_phase)
                PH_WAIT: begin
                    if (i_byte == BYTE_BREAK) n_phase = PH_BREAK;
                    else if (i_byte == BYTE_EXT) n_phase = PH_EXT;
                end
                PH_EXT: begin
                    if (i_byte == CODE_SHIFT_L) n_phase = PH_FAKE;
                    else if (i_byte == BYTE_BREAK) n_phase = PH_EXT_BREAK;
                    else n_phase = PH_WAIT;
                end
                PH_FAKE: begin
                    if (i_byte == BYTE_EXT) n_phase = PH_EXT;
                end
                PH_EXT_BREAK: n_phase = PH_WAIT;
                PH_BREAK:     n_phase = PH_WAIT;
                default:      n_phase = PH_WAIT;
            endcase
        end
    end

    // Whether this byte completes a key sequence, and how.
    always_comb begin
        key_seen    = 1'b0;
        key_ext     = 1'b0;
        key_pressed = 1'b0;
        if (!filtered) begin
            case (r_phase)
                PH_WAIT: begin
                    key_seen    = (i_byte != BYTE_BREAK) && (i_byte != BYTE_EXT);
                    key_pressed = 1'b1;
                end
                PH_EXT: begin
                    key_seen    = (i_byte != CODE_SHIFT_L) && (i_byte != BYTE_BREAK);
                    key_ext     = 1'b1;
                    key_pressed = 1'b1;
                end
                PH_EXT_BREAK: begin
                    key_seen = (i_byte != CODE_SHIFT_L);
                    key_ext  = 1'b1;
                end
                PH_BREAK: key_seen = 1'b1;
                PH_FAKE:  key_seen = 1'b0;
                default:  key_seen = 1'b0;
            endcase
        end
    end

    assign lk = lock_bit(i_byte, key_ext);
    assign md = modifier_bit(i_byte, key_ext);

    // Flag updates and the result for the completed key.
    always_comb begin
        n_locks  = r_locks;
        n_mods   = r_mods;
        o_emit   = 1'b0;
        o_result = '0;
        if (key_seen) begin
            if (lk != 3'b000) begin
                if (key_pressed) begin
                    n_locks        = r_locks ^ lk;
                    o_emit         = 1'b1;
                    o_result.kind  = KIND_LED;
                    o_result.locks = n_locks;
                end
            end else begin
                n_mods             = key_pressed ? (r_mods | md) : (r_mods & ~md);
                o_emit             = 1'b1;
                o_result.kind      = KIND_KEY;
                o_result.scancode  = i_byte;
                o_result.extended  = key_ext;
                o_result.pressed   = key_pressed;
                o_result.modifiers = n_mods;
                o_result.locks     = r_locks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_locks <= '0;
            r_mods  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_locks <= n_locks;
            r_mods  <= n_mods;
        end
    end
endmodule

>>> rtl/ksd_out_stage.sv
// Result register that holds one decoded result until the consumer takes it.
module ksd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_emit,
    input  ksd_pkg::t_result i_result,
    output logic             o_can_load,
    ksd_result_if.source     o_res
);
    import ksd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_emit;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.result_kind   = r_res.kind;
    assign o_res.key_scancode  = r_res.scancode;
    assign o_res.is_extended   = r_res.extended;
    assign o_res.is_pressed    = r_res.pressed;
    assign o_res.modifier_mask = r_res.modifiers;
    assign o_res.lock_mask     = r_res.locks;
endmodule

>>> rtl/keyboard_scancode_set2_decoder_top.sv
// Top level of the PS/2 scancode set 2 decoder.
//
//  Channel   Direction  Payload                                  Transfer when
//  i_rx      in         rx_byte                                  valid && ready
//  o_res     out        kind, scancode, ext, pressed, mods, locks valid && ready
//  i_cfg     in         ack filter enable (1 bit)                i_cfg_we
//
// Each received byte is held in the input register and is decoded on its way into
// the result register, so a byte can be taken in every cycle while the result side
// does not stall. Its result passes the input register and then the result
// register before it reaches the result port.
// The whole rate is set by the single decode step between the two registers.
// Reset is synchronous and active low; it clears both valid flags, the prefix
// state, the lock flags and the held modifiers, and turns the ACK/NAK filter on.
// A stalled result holds the result register; the input register still takes
// one more byte, and only then is i_rx.ready lowered.
`include "assert_macros.svh"

module keyboard_scancode_set2_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    ksd_byte_if.sink     i_rx,
    ksd_result_if.source o_res
);
    import ksd_pkg::*;

    logic       r_ack_filter_en;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_can_load;
    logic       advance;
    logic       dec_emit;
    t_result    dec_result;

    // The filter enable resets to on, so device command responses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_filter_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_ack_filter_en <= i_cfg_wdata;
        end
    end

    // A byte is decoded, and the state updated, only when its result has a place
    // to go. Bytes that yield no result still pass through this step.
    assign advance = in_valid && out_can_load;

    ksd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .i_rx      (i_rx)
    );

    ksd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (in_byte),
        .i_ack_filter (r_ack_filter_en),
        .o_emit       (dec_emit),
        .o_result     (dec_result)
    );

    ksd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_emit     (dec_emit),
        .i_result   (dec_result),
        .o_can_load (out_can_load),
        .o_res      (o_res)
    );

    // An LED request carries nothing but the lock flags.
    `KSD_ASSERT_NOW(a_led_fields_clear, i_clk, i_rst_n, o_res.valid && (o_res.result_kind == KIND_LED), (o_res.key_scancode == 8'h00) && !o_res.is_extended && !o_res.is_pressed && (o_res.modifier_mask == 6'h00))

    // A filtered command response never turns into a result.
    `KSD_ASSERT_NEXT(a_ack_dropped, i_clk, i_rst_n, advance && r_ack_filter_en && ((in_byte == BYTE_ACK) || (in_byte == BYTE_NAK)), !o_res.valid)

    // Input back-pressure only arises from a full pipe with a stalled result.
    `KSD_ASSERT_NOW(a_ready_low_only_when_full, i_clk, i_rst_n, !i_rx.ready, in_valid && o_res.valid && !o_res.ready)
endmodule

>>> dv/keyboard_scancode_set2_decoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the scancode set 2 decoder with its own decoding predictor.
module keyboard_scancode_set2_decoder_top_tb;
    import ksd_pkg::*;

    // A byte passes the input register and then the result register, so this much
    // settling is ample for a byte that causes none.
    localparam int SETTLE      = 4;
    // The watchdog bound lies far above the length of the whole run.
    localparam int CYCLE_LIMIT = 100000;
    // The long hold-off of the result side starts once this many results have gone.
    localparam int STALL_AT    = 60;
    localparam int STALL_LEN   = 300;
    // Each side idles with a chance of 17 in a hundred, unless steady is set.
    localparam int IDLE_PCT    = 17;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ksd_byte_if   rx_ch ();
    ksd_result_if res_ch ();

    keyboard_scancode_set2_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    // Bytes waiting to be offered, and the key reports the predictor expects back.
    logic [7:0] rx_backlog[$];
    t_result    pending_reports[$];

    // The predictor's own copy of the decoder state and of the filter register.
    t_phase     dec_phase;
    logic [2:0] lock_state;
    logic [5:0] mod_state;
    logic       filter_on;

    int         bytes_queued;
    int         results_seen;
    int         fail_count;
    int         cycle_count;
    int         stall_left;
    logic       stall_done;
    logic       steady;
    t_result    head_report;
    t_result    got_report;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A fully decoded key. Lock keys toggle their flag on the press and ask for an
    // LED update; their release is swallowed. Anything else is a key event, with
    // the modifier mask already reflecting this key.
    task automatic report_key(input logic [7:0] code, input logic ext, input logic pressed);
        logic [2:0] lk;
        logic [5:0] md;
        t_result    rep;
        lk = '0;
        md = '0;
        rep = '0;
        if (!ext) begin
            case (code)
                CODE_SCROLL:  lk = LOCK_SCROLL;
                CODE_NUM:     lk = LOCK_NUM;
                CODE_CAPS:    lk = LOCK_CAPS;
                CODE_SHIFT_L: md = MOD_LSHIFT;
                CODE_SHIFT_R: md = MOD_RSHIFT;
                CODE_CTRL:    md = MOD_LCTRL;
                CODE_ALT:     md = MOD_LALT;
                default: ;
            endcase
        end else begin
            case (code)
                CODE_CTRL: md = MOD_RCTRL;
                CODE_ALT:  md = MOD_RALT;
                default: ;
            endcase
        end
        if (lk != '0) begin
            if (pressed) begin
                lock_state = lock_state ^ lk;
                rep.kind = KIND_LED;
                rep.locks = lock_state;
                pending_reports.push_back(rep);
            end
        end else begin
            if (pressed) begin
                mod_state = mod_state | md;
            end else begin
                mod_state = mod_state & ~md;
            end
            rep.kind = KIND_KEY;
            rep.scancode = code;
            rep.extended = ext;
            rep.pressed = pressed;
            rep.modifiers = mod_state;
            rep.locks = lock_state;
            pending_reports.push_back(rep);
        end
    endtask

    // One accepted byte through the prefix machine. The fake-shift sequence E0 12
    // parks the machine until the next E0, and E0 F0 12 ends it without a report.
    task automatic decode_rx_byte(input logic [7:0] b);
        if (filter_on && (b == BYTE_ACK || b == BYTE_NAK)) begin
            return;
        end
        case (dec_phase)
            PH_WAIT: begin
                if (b == BYTE_BREAK) begin
                    dec_phase = PH_BREAK;
                end else if (b == BYTE_EXT) begin
                    dec_phase = PH_EXT;
                end else begin
                    report_key(b, 1'b0, 1'b1);
                end
            end
            PH_EXT: begin
                if (b == CODE_SHIFT_L) begin
                    dec_phase = PH_FAKE;
                end else if (b == BYTE_BREAK) begin
                    dec_phase = PH_EXT_BREAK;
                end else begin
                    report_key(b, 1'b1, 1'b1);
                    dec_phase = PH_WAIT;
                end
            end
            PH_FAKE: begin
                if (b == BYTE_EXT) begin
                    dec_phase = PH_EXT;
                end
            end
            PH_EXT_BREAK: begin
                if (b != CODE_SHIFT_L) begin
                    report_key(b, 1'b1, 1'b0);
                end
                dec_phase = PH_WAIT;
            end
            PH_BREAK: begin
                report_key(b, 1'b0, 1'b0);
                dec_phase = PH_WAIT;
            end
            default: dec_phase = PH_WAIT;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Byte driver: offers the backlog, idling at random, and feeds every
    // transfer to the predictor at the edge where it takes place.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid <= 1'b0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                decode_rx_byte(rx_ch.rx_byte);
            end
            // A new byte may only be put up once the current one has gone. The valid
            // flag gets exactly one assignment here, so back-to-back transfers hold it.
            if (!rx_ch.valid || rx_ch.ready) begin
                if (rx_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    rx_ch.valid <= 1'b1;
                    rx_ch.rx_byte <= rx_backlog.pop_front();
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, plus one long hold-off that lets the
    // decoder fill both registers and push back on the byte channel while the
    // driver keeps offering.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (stall_left != 0) begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && results_seen >= STALL_AT) begin
            res_ch.ready <= 1'b0;
            stall_left <= STALL_LEN;
            stall_done <= 1'b1;
        end else begin
            res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Every result transfer is matched against the oldest expected report.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen <= results_seen + 1;
            got_report.kind = t_kind'(res_ch.result_kind);
            got_report.scancode = res_ch.key_scancode;
            got_report.extended = res_ch.is_extended;
            got_report.pressed = res_ch.is_pressed;
            got_report.modifiers = res_ch.modifier_mask;
            got_report.locks = res_ch.lock_mask;
            if (pending_reports.size() == 0) begin
                $error("unexpected result: kind %0d scancode 0x%0h", got_report.kind,
                       got_report.scancode);
                fail_count++;
            end else begin
                head_report = pending_reports.pop_front();
                check_field("result_kind", head_report.kind, got_report.kind);
                check_field("key_scancode", head_report.scancode, got_report.scancode);
                check_field("is_extended", head_report.extended, got_report.extended);
                check_field("is_pressed", head_report.pressed, got_report.pressed);
                check_field("modifier_mask", head_report.modifiers, got_report.modifiers);
                check_field("lock_mask", head_report.locks, got_report.locks);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    // Codes with a meaning of their own turn up often; the rest is any byte.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(13))
            0:       return CODE_SHIFT_L;
            1:       return CODE_SHIFT_R;
            2:       return CODE_CTRL;
            3:       return CODE_ALT;
            4:       return CODE_CAPS;
            5:       return CODE_NUM;
            6:       return CODE_SCROLL;
            7:       return BYTE_ACK;
            8:       return BYTE_NAK;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed key sequences with random codes, some fake-shift wrapping,
    // stray ACK/NAK bytes and a share of raw noise that may break a sequence.
    task automatic queue_random(input int n_bytes);
        int target;
        int pick;
        logic [7:0] code;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) begin
            code = pick_code();
            pick = $urandom_range(99);
            if (pick < 26) begin
                queue_byte(code);
            end else if (pick < 50) begin
                queue_byte(BYTE_BREAK);
                queue_byte(code);
            end else if (pick < 62) begin
                queue_byte(BYTE_EXT);
                queue_byte(code);
            end else if (pick < 74) begin
                queue_byte(BYTE_EXT);
                queue_byte(BYTE_BREAK);
                queue_byte(code);
            end else if (pick < 80) begin
                // Fake shift ahead of an extended key, sometimes with a stray byte inside.
                queue_byte(BYTE_EXT);
                queue_byte(CODE_SHIFT_L);
                if ($urandom_range(1) == 0) begin
                    queue_byte(8'($urandom));
                end
                queue_byte(BYTE_EXT);
                queue_byte(code);
            end else if (pick < 84) begin
                queue_byte(BYTE_EXT);
                queue_byte(BYTE_BREAK);
                queue_byte(CODE_SHIFT_L);
            end else if (pick < 90) begin
                queue_byte($urandom_range(1) ? BYTE_ACK : BYTE_NAK);
            end else begin
                queue_byte(8'($urandom));
            end
        end
    endtask

    // Waits until every byte has gone in and every report has come out, then lets
    // the last result-free bytes clear the pipeline. The check is made at the
    // falling edge, where the handshake signals have settled.
    task automatic wait_drained();
        while (rx_backlog.size() != 0 || rx_ch.valid || pending_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_filter(input logic value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        filter_on = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        steady = 1'b0;
        bytes_queued = 0;
        results_seen = 0;
        fail_count = 0;
        dec_phase = PH_WAIT;
        lock_state = '0;
        mod_state = '0;
        filter_on = 1'b1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the filter at its reset value: byte extremes, the
        // modifiers, a lock press and its silent release, fake shift in both forms,
        // and ACK/NAK being dropped.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CODE_SHIFT_L);
        queue_byte(BYTE_EXT);
        queue_byte(CODE_CTRL);
        queue_byte(BYTE_EXT);
        queue_byte(CODE_ALT);
        queue_byte(CODE_CAPS);
        queue_byte(BYTE_BREAK);
        queue_byte(CODE_CAPS);
        queue_byte(CODE_NUM);
        queue_byte(CODE_SCROLL);
        queue_byte(BYTE_EXT);
        queue_byte(CODE_SHIFT_L);
        queue_byte(8'h34);
        queue_byte(BYTE_EXT);
        queue_byte(BYTE_BREAK);
        queue_byte(CODE_SHIFT_L);
        queue_byte(BYTE_ACK);
        queue_byte(BYTE_NAK);
        queue_byte(BYTE_EXT);
        queue_byte(CODE_SCROLL);
        queue_byte(BYTE_BREAK);
        queue_byte(CODE_SHIFT_L);
        wait_drained();

        // With the filter off, ACK and NAK are ordinary codes, even after a prefix.
        write_filter(1'b0);
        queue_byte(BYTE_ACK);
        queue_byte(BYTE_BREAK);
        queue_byte(BYTE_NAK);
        queue_byte(BYTE_EXT);
        queue_byte(BYTE_ACK);
        queue_random(150);
        wait_drained();

        // Filter back on: first a stretch with no idling on either side, then the
        // usual random idling.
        write_filter(1'b1);
        steady <= 1'b1;
        queue_random(100);
        wait_drained();
        steady <= 1'b0;
        queue_random(170);
        wait_drained();

        write_filter(1'b0);
        queue_random(60);
        wait_drained();
        repeat (2 * SETTLE) @(posedge i_clk);

        if (pending_reports.size() != 0) begin
            $error("missing results: %0d expected reports never arrived",
                   pending_reports.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
